// ===== hw/rtl/fifo_with_min_max_tracking_macros.svh =====
// Assertion macros for the min/max tracking FIFO.
// Used by the checker; expects clk, rst_n and out_valid in scope.
`ifndef FIFO_WITH_MIN_MAX_TRACKING_MACROS_SVH
`define FIFO_WITH_MIN_MAX_TRACKING_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define FMMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold whenever a result is offered.
`define FMMT_ASSERT_OUT(lbl, cond, msg) \
  `FMMT_ASSERT(lbl, out_valid |-> (cond), msg)

`endif

// ===== hw/rtl/fmmt_pkg.sv =====
// Shared types and codes for the min/max tracking FIFO.
// No dependencies; imported by every module of the block but fmmt_ram.
package fmmt_pkg;

  localparam int DATA_W = 32;
  localparam int OCC_W  = 7;
  localparam int STS_W  = 2;

  // Operation codes.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Status codes.
  localparam logic [STS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STS_W-1:0] STS_POP_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] STS_PUSH_FULL = 2'd2;

  typedef struct packed {
    logic                     op;
    logic signed [DATA_W-1:0] value;
  } fmmt_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] min_value;
    logic signed [DATA_W-1:0] max_value;
    logic        [OCC_W-1:0]  occupancy;
    logic                     is_empty;
    logic        [STS_W-1:0]  status;
  } fmmt_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load_in;
    logic             push;
    logic             pop;
    logic             sts_we;
    logic [STS_W-1:0] sts_code;
    logic             scan_run;
    logic             out_load;
  } fmmt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op;
    logic full;
    logic empty;
    logic multi;
    logic scan_done;
  } fmmt_sts_t;

endpackage

// ===== hw/rtl/fifo_with_min_max_tracking.sv =====
// Top level of the FIFO that tracks the minimum and maximum of its contents.
// Depends on fmmt_pkg, fmmt_ctrl and fmmt_dp.
//
//   channel  ports                            payload
//   input    in_valid / in_ready / in_data    fmmt_in_t  (op, value)
//   result   out_valid / out_ready / out_data fmmt_out_t (front, min, max, ...)
//
// One item at a time. A push, a rejected operation or a pop that empties the queue
// raises the result through the EXEC and FIN states. A pop that leaves entries behind
// also passes the SCAN state: the single read port of the entry RAM rescans one entry per cycle.
// The next item is taken while a result waits in the output register.
// Reset is synchronous; the entry RAM is not cleared, only held entries are read.
module fifo_with_min_max_tracking
  import fmmt_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  fmmt_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output fmmt_out_t out_data
);

  fmmt_cmd_t cmd;
  fmmt_sts_t sts;

  fmmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fmmt_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ===== hw/rtl/fmmt_ram.sv =====
// Generic simple dual-port RAM with a registered read.
// No dependencies.
module fmmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/fmmt_ctrl.sv =====
// Controller state machine for the min/max tracking FIFO.
// Depends on fmmt_pkg; drives the datapath through fmmt_cmd_t.
module fmmt_ctrl
  import fmmt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  fmmt_sts_t sts,
  output fmmt_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.sts_we = 1'b1;
        state_nxt  = S_FIN;
        if (sts.op == OP_PUSH) begin
          if (sts.full) begin
            cmd.sts_code = STS_PUSH_FULL;
          end else begin
            cmd.sts_code = STS_OK;
            cmd.push     = 1'b1;
          end
        end else begin
          if (sts.empty) begin
            cmd.sts_code = STS_POP_EMPTY;
          end else begin
            cmd.sts_code = STS_OK;
            cmd.pop      = 1'b1;
            if (sts.multi) begin
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid holds until the transfer completes.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/fmmt_dp.sv =====
// Datapath for the min/max tracking FIFO: pointers, extremes, rescan, result.
// Depends on fmmt_pkg and fmmt_ram.
module fmmt_dp
  import fmmt_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  fmmt_in_t  in_data,
  input  fmmt_cmd_t cmd,
  output fmmt_sts_t sts,
  output fmmt_out_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic                     op_r;
  logic signed [DATA_W-1:0] value_r;
  logic [AW-1:0]            head_r, head_nxt;
  logic [AW-1:0]            tail_r, tail_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic signed [DATA_W-1:0] min_r, min_nxt;
  logic signed [DATA_W-1:0] max_r, max_nxt;
  logic signed [DATA_W-1:0] front_r, front_nxt;
  logic [STS_W-1:0]         status_r;
  logic [AW-1:0]            scan_addr_r, scan_addr_nxt;
  logic [CW-1:0]            scan_left_r, scan_left_nxt;
  logic                     rd_vld_r, rd_vld_nxt;
  logic                     first_r, first_nxt;
  logic                     rd_en;
  logic [DATA_W-1:0]        rd_data;
  logic signed [DATA_W-1:0] rd_val;
  fmmt_out_t                out_r;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
    next_slot = (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
  endfunction

  fmmt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (tail_r),
    .wdata (value_r),
    .re    (rd_en),
    .raddr (scan_addr_r),
    .rdata (rd_data)
  );

  assign rd_val = $signed(rd_data);
  assign rd_en  = cmd.scan_run && (scan_left_r != '0);

  // Push, pop and the rescan that rebuilds front, min and max.
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    front_nxt     = front_r;
    scan_addr_nxt = scan_addr_r;
    scan_left_nxt = scan_left_r;
    first_nxt     = first_r;
    rd_vld_nxt    = 1'b0;
    if (cmd.push) begin
      tail_nxt  = next_slot(tail_r);
      count_nxt = count_r + CW'(1);
      if (count_r == '0) begin
        min_nxt   = value_r;
        max_nxt   = value_r;
        front_nxt = value_r;
      end else begin
        if (value_r < min_r) min_nxt = value_r;
        if (value_r > max_r) max_nxt = value_r;
      end
    end
    if (cmd.pop) begin
      head_nxt      = next_slot(head_r);
      count_nxt     = count_r - CW'(1);
      scan_addr_nxt = next_slot(head_r);
      scan_left_nxt = count_r - CW'(1);
      first_nxt     = 1'b1;
      min_nxt       = '0;
      max_nxt       = '0;
      front_nxt     = '0;
    end
    if (rd_en) begin
      scan_addr_nxt = next_slot(scan_addr_r);
      scan_left_nxt = scan_left_r - CW'(1);
      rd_vld_nxt    = 1'b1;
    end
    // Fold in the entry read on the previous cycle.
    if (rd_vld_r) begin
      first_nxt = 1'b0;
      if (first_r) begin
        front_nxt = rd_val;
        min_nxt   = rd_val;
        max_nxt   = rd_val;
      end else begin
        if (rd_val < min_r) min_nxt = rd_val;
        if (rd_val > max_r) max_nxt = rd_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      min_r       <= '0;
      max_r       <= '0;
      scan_left_r <= '0;
      rd_vld_r    <= 1'b0;
      first_r     <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      scan_left_r <= scan_left_nxt;
      rd_vld_r    <= rd_vld_nxt;
      first_r     <= first_nxt;
    end
  end

  // Payload registers: captured item, front, scan address, status, result.
  always_ff @(posedge clk) begin
    front_r     <= front_nxt;
    scan_addr_r <= scan_addr_nxt;
    if (cmd.load_in) begin
      op_r    <= in_data.op;
      value_r <= in_data.value;
    end
    if (cmd.sts_we) begin
      status_r <= cmd.sts_code;
    end
    if (cmd.out_load) begin
      out_r.occupancy <= OCC_W'(count_r);
      out_r.status    <= status_r;
      if (count_r == '0) begin
        out_r.front_value <= '0;
        out_r.min_value   <= '0;
        out_r.max_value   <= '0;
        out_r.is_empty    <= 1'b1;
      end else begin
        out_r.front_value <= front_r;
        out_r.min_value   <= min_r;
        out_r.max_value   <= max_r;
        out_r.is_empty    <= 1'b0;
      end
    end
  end

  assign sts.op        = op_r;
  assign sts.full      = (count_r == CW'(DEPTH));
  assign sts.empty     = (count_r == '0);
  assign sts.multi     = (count_r > CW'(1));
  assign sts.scan_done = (scan_left_r == '0) && !rd_vld_r;
  assign out_data      = out_r;

endmodule

// ===== hw/rtl/fmmt_chk.sv =====
// Port-level checks for the min/max tracking FIFO, bound to the top level.
// Depends on fmmt_pkg and fifo_with_min_max_tracking_macros.svh.
`include "fifo_with_min_max_tracking_macros.svh"

module fmmt_chk
  import fmmt_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input fmmt_out_t out_data
);

  // A stalled result holds its payload.
  `FMMT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")

  // Only one item is in work: no transfer right after another.
  `FMMT_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "input ready right after a transfer")

  // An empty queue reports zero values.
  `FMMT_ASSERT_OUT(a_empty_zero, !out_data.is_empty || (out_data.occupancy == '0 && out_data.front_value == '0 && out_data.min_value == '0 && out_data.max_value == '0), "empty result carries values")

  // Front lies between min and max.
  `FMMT_ASSERT_OUT(a_order, out_data.is_empty || ($signed(out_data.min_value) <= $signed(out_data.front_value) && $signed(out_data.front_value) <= $signed(out_data.max_value)), "front outside min and max")

  // A pop on empty leaves the queue empty.
  `FMMT_ASSERT_OUT(a_pop_empty, out_data.status != STS_POP_EMPTY || out_data.is_empty, "pop on empty with entries held")

endmodule

bind fifo_with_min_max_tracking fmmt_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== test/testbench.sv =====
// Self-checking testbench for the FIFO that tracks the minimum and maximum of its contents.
// Depends on fmmt_pkg and fifo_with_min_max_tracking. A local FIFO model predicts each result,
// and the monitor compares every result transfer with the oldest prediction.
`timescale 1ns / 100ps

module testbench;
  import fmmt_pkg::*;

  localparam int FIFO_DEPTH   = 64;
  localparam int ITEM_TARGET  = 700;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLDOFF_LEN  = 300;
  localparam int HOLDOFF_AT   = 150;
  localparam int TAIL_CYCLES  = 100;
  localparam int REPORT_LIMIT = 10;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  fmmt_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  fmmt_out_t out_data;

  // Stimulus waiting to be driven, and results the model says are still to come.
  fmmt_in_t  pending_items[$];
  fmmt_out_t expected_results[$];

  // Contents of the FIFO as the model sees them, oldest first.
  logic signed [DATA_W-1:0] model_entries[$];

  int fail_count     = 0;
  int items_total    = 0;
  int items_accepted = 0;
  int results_seen   = 0;
  int cycle_count    = 0;
  int gen_occupancy  = 0;

  fifo_with_min_max_tracking #(
    .DEPTH(FIFO_DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Clock generation.
  initial begin
    forever #2 clk = ~clk;
  end

  // Cycle counter for the run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Apply one operation to the model and return the result the block must report.
  function automatic fmmt_out_t model_fifo_step(fmmt_in_t item);
    fmmt_out_t                res;
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
    res = '0;
    res.status = STS_OK;
    if (item.op == OP_PUSH) begin
      if (model_entries.size() >= FIFO_DEPTH) begin
        res.status = STS_PUSH_FULL;
      end else begin
        model_entries.push_back(item.value);
      end
    end else begin
      if (model_entries.size() == 0) begin
        res.status = STS_POP_EMPTY;
      end else begin
        void'(model_entries.pop_front());
      end
    end
    res.occupancy = OCC_W'(model_entries.size());
    if (model_entries.size() == 0) begin
      res.is_empty = 1'b1;
    end else begin
      // The extremes always cover exactly the entries that remain.
      lo = model_entries[0];
      hi = model_entries[0];
      foreach (model_entries[i]) begin
        if (model_entries[i] < lo) lo = model_entries[i];
        if (model_entries[i] > hi) hi = model_entries[i];
      end
      res.front_value = model_entries[0];
      res.min_value   = lo;
      res.max_value   = hi;
      res.is_empty    = 1'b0;
    end
    return res;
  endfunction

  // Queue one operation and keep track of the occupancy it leads to.
  task automatic add_item(logic op, logic signed [DATA_W-1:0] value);
    fmmt_in_t item;
    item.op    = op;
    item.value = value;
    pending_items.push_back(item);
    items_total++;
    if (op == OP_PUSH && gen_occupancy < FIFO_DEPTH) gen_occupancy++;
    if (op == OP_POP && gen_occupancy > 0) gen_occupancy--;
  endtask

  // Values lean on the extremes and on a narrow band so that duplicates occur.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0: begin
        return VAL_MIN;
      end
      1: begin
        return VAL_MAX;
      end
      2, 3: begin
        return $signed(DATA_W'($urandom_range(0, 8))) - 4;
      end
      default: begin
        return $signed($urandom);
      end
    endcase
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string field_name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      note_failure($sformatf("result %0d: %s expected %h, got %h",
                             results_seen, field_name, want, got));
    end
  endtask

  // Driver: offers queued items in bursts with random gaps, and predicts each transfer.
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(model_fifo_step(in_data));
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_items.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left = burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness: a rotating stall pattern, plus one long hold-off.
  logic [7:0] stall_pattern = 8'hff;
  int         pattern_age   = 0;
  int         holdoff_left  = 0;
  logic       holdoff_done  = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left = holdoff_left - 1;
      out_ready <= 1'b0;
    end else if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_LEN - 1;
      out_ready <= 1'b0;
    end else begin
      if (pattern_age == 0) begin
        stall_pattern = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom);
        pattern_age   = $urandom_range(16, 96);
      end else begin
        pattern_age = pattern_age - 1;
      end
      stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
      out_ready <= stall_pattern[0];
    end
  end

  // Monitor: each result transfer is matched against the oldest prediction.
  always @(posedge clk) begin
    fmmt_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result %h with nothing predicted", out_data));
      end else begin
        want = expected_results.pop_front();
        check_field("front_value", want.front_value, out_data.front_value);
        check_field("min_value", want.min_value, out_data.min_value);
        check_field("max_value", want.max_value, out_data.max_value);
        check_field("occupancy", DATA_W'(want.occupancy), DATA_W'(out_data.occupancy));
        check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(out_data.is_empty));
        check_field("status", DATA_W'(want.status), DATA_W'(out_data.status));
      end
      results_seen <= results_seen + 1;
    end
  end

  // Run limit.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("fifo_with_min_max_tracking regression: fail");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    int mode;
    int run_len;
    int leftover;

    // Directed part: empty pops, extremes, departing extremes, duplicates and draining.
    add_item(OP_POP, $signed($urandom));
    add_item(OP_PUSH, 0);
    add_item(OP_POP, VAL_MAX);
    add_item(OP_POP, VAL_MIN);
    add_item(OP_PUSH, VAL_MIN);
    add_item(OP_PUSH, VAL_MAX);
    add_item(OP_PUSH, -1);
    add_item(OP_PUSH, 1);
    add_item(OP_POP, -1);
    add_item(OP_POP, 0);
    add_item(OP_PUSH, 5);
    add_item(OP_PUSH, 5);
    add_item(OP_PUSH, -1);
    add_item(OP_POP, 32'sh5555_5555);
    add_item(OP_POP, 32'shaaaa_aaaa);
    add_item(OP_POP, 0);
    add_item(OP_POP, 0);
    add_item(OP_POP, 0);
    add_item(OP_PUSH, 32'sh7777_7777);
    add_item(OP_PUSH, 32'sh7777_7777);
    add_item(OP_POP, 0);
    add_item(OP_POP, 0);

    // Random part, mostly structured runs: mixed traffic, fills past full, drains past empty.
    while (items_total < ITEM_TARGET) begin
      mode = $urandom_range(0, 9);
      if (mode < 4) begin
        run_len = $urandom_range(10, 40);
        repeat (run_len) begin
          if ($urandom_range(0, 9) < 6) add_item(OP_PUSH, pick_value());
          else add_item(OP_POP, $signed($urandom));
        end
      end else if (mode < 6) begin
        run_len = FIFO_DEPTH - gen_occupancy + $urandom_range(1, 4);
        repeat (run_len) add_item(OP_PUSH, pick_value());
      end else if (mode < 8) begin
        run_len = gen_occupancy + $urandom_range(1, 3);
        repeat (run_len) add_item(OP_POP, $signed($urandom));
      end else begin
        run_len = $urandom_range(5, 15);
        repeat (run_len) add_item(1'($urandom), $signed($urandom));
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    leftover = 1;
    while (leftover != 0) begin
      @(posedge clk);
      leftover = (items_accepted < items_total || expected_results.size() != 0) ? 1 : 0;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("fifo_with_min_max_tracking regression: pass");
    end else begin
      $display("fifo_with_min_max_tracking regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/fmmt_pkg.sv
hw/rtl/fmmt_ram.sv
hw/rtl/fmmt_ctrl.sv
hw/rtl/fmmt_dp.sv
hw/rtl/fifo_with_min_max_tracking.sv
hw/rtl/fmmt_chk.sv
test/testbench.sv
